### src/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants, codes and controller/datapath interface types for the
// stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int DEPTH_W     = 5;
  localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    K_PUSH  = 3'd0,
    K_POP   = 3'd1,
    K_ADD   = 3'd2,
    K_SUB   = 3'd3,
    K_MUL   = 3'd4,
    K_DIV   = 3'd5,
    K_SWAP  = 3'd6,
    K_CLEAR = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // Which stack slot a write goes to.
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_PUSH = 2'd1,  // slot at the fill count, grows the stack
    WR_LOW  = 2'd2,  // second entry from the top
    WR_HIGH = 2'd3   // top entry
  } wr_sel_t;

  typedef struct packed {
    kind_t   op;
    logic    cap_in;
    logic    rd_en;
    logic    cap_b;
    logic    load_top_rd;
    logic    cap_pop;
    logic    mul_go;
    logic    div_start;
    wr_sel_t wr_sel;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    out_ld;
    logic    show_pop;
    status_t out_status;
  } rsc_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic lt2;
    logic top_zero;
    logic div_done;
    logic out_free;
  } rsc_stat_t;

endpackage

### src/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Bounded stack of 32-bit integers driven by one operation per input beat.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every input beat yields exactly one
// output beat. Push, clear and rejected operations go from decode straight to
// output; pop adds a stack read, add and subtract a read and one write-back,
// multiply a read, a multiply step and one write-back, swap a read and two
// write-backs, and divide a read, the divider run and two write-backs. The
// entries sit in a RAM with one write port and one registered read port, so
// each operation reads at most one entry besides the cached top. A finished
// result waits in the output register; a new item is taken while it waits,
// and only the final hand-off stalls on m_tready.
module rpn_stack_calculator import rsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] top_or_popped, [36:32] depth, zero pad
  output logic [1:0]  m_tuser    // [1:0] status
);

  rsc_cmd_t           cmd;
  rsc_stat_t          stat;
  logic [DATA_W-1:0]  out_data;
  status_t            out_status;
  logic [DEPTH_W-1:0] out_depth;

  rsc_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .kind_in (kind_t'(s_tuser)),
    .stat    (stat),
    .cmd     (cmd)
  );

  rsc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .operand_in(s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .out_status(out_status),
    .out_depth (out_depth)
  );

  assign m_tdata = {3'b000, out_depth, out_data};
  assign m_tuser = out_status;

  // An accepted beat always leaves the block busy, so s_tready drops after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // Overflow is only reported with the stack at full depth.
  a_over_at_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OVER) |-> (m_tdata[36:32] == DEPTH_W'(STACK_DEPTH)))
    else $error("overflow reported below full depth");

  // A waiting output beat holds still until it is taken.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output beat changed while stalled");

endmodule

### src/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rsc_divider.sv
// ----------------------------------------------------------------------------
// rsc_divider
// Iterative restoring divider, one quotient bit per cycle, with truncating
// signed correction applied to the magnitudes at the output.
// ----------------------------------------------------------------------------
module rsc_divider import rsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [DATA_W-1:0] quo,
  output logic [DATA_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] steps;
  logic [DATA_W-1:0]    q;
  logic [DATA_W-1:0]    r;
  logic [DATA_W-1:0]    dmag;
  logic                 qneg;
  logic                 rneg;
  logic [DATA_W:0]      sh;
  logic [DATA_W:0]      diff;
  logic                 ge;

  assign sh   = {r, q[DATA_W-1]};
  assign diff = sh - {1'b0, dmag};
  assign ge   = !diff[DATA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == DIV_CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DATA_W);
      end else if (busy) begin
        steps <= steps - DIV_CNT_W'(1);
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q    <= num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
      r    <= '0;
      dmag <= den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
      qneg <= num[DATA_W-1] ^ den[DATA_W-1];
      rneg <= num[DATA_W-1];
    end else if (busy) begin
      q <= {q[DATA_W-2:0], ge};
      r <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
    end
  end

  // The most negative value over minus one wraps back to itself here.
  assign quo = qneg ? (~q + DATA_W'(1)) : q;
  assign rem = rneg ? (~r + DATA_W'(1)) : r;

endmodule

### src/rsc_datapath.sv
// ----------------------------------------------------------------------------
// rsc_datapath
// Stack storage, cached top entry, fill count, arithmetic units and the
// output register.
// ----------------------------------------------------------------------------
module rsc_datapath import rsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  rsc_cmd_t           cmd,
  output rsc_stat_t          stat,
  input  logic [DATA_W-1:0]  operand_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_data,
  output status_t            out_status,
  output logic [DEPTH_W-1:0] out_depth
);

  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] operand_q;
  logic [DATA_W-1:0] top_q;
  logic [DATA_W-1:0] opb_q;
  logic [DATA_W-1:0] popped_q;
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] low_val;
  logic [DATA_W-1:0] high_val;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic              div_done;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;

  assign stat.empty    = (cnt == '0);
  assign stat.full     = (cnt == CNT_W'(STACK_DEPTH));
  assign stat.lt2      = (cnt < CNT_W'(2));
  assign stat.top_zero = (top_q == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.op)
      K_ADD:   low_val = opb_q + top_q;
      K_SUB:   low_val = opb_q - top_q;
      K_MUL:   low_val = prod_q;
      K_DIV:   low_val = rem;
      default: low_val = top_q;
    endcase
    high_val = (cmd.op == K_DIV) ? quo : opb_q;
  end

  always_comb begin
    we    = (cmd.wr_sel != WR_NONE);
    raddr = AW'(cnt - CNT_W'(2));
    unique case (cmd.wr_sel)
      WR_PUSH: begin
        waddr = AW'(cnt);
        wdata = operand_q;
      end
      WR_LOW: begin
        waddr = AW'(cnt - CNT_W'(2));
        wdata = low_val;
      end
      WR_HIGH: begin
        waddr = AW'(cnt - CNT_W'(1));
        wdata = high_val;
      end
      default: begin
        waddr = AW'(cnt);
        wdata = operand_q;
      end
    endcase
  end

  rsc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  rsc_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (opb_q),
    .den  (top_q),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.wr_sel == WR_PUSH) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The top entry is cached so that most operations need only one read.
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      operand_q <= operand_in;
    end
    if (cmd.cap_b) begin
      opb_q <= rdata;
    end
    if (cmd.cap_pop) begin
      popped_q <= stat.empty ? INT_MIN : top_q;
    end
    if (cmd.mul_go) begin
      prod_q <= DATA_W'(top_q * opb_q);
    end
    if (cmd.load_top_rd) begin
      top_q <= rdata;
    end else if (we) begin
      top_q <= (cmd.wr_sel == WR_LOW) ? low_val : wdata;
    end
    if (cmd.out_ld) begin
      out_data   <= cmd.show_pop ? popped_q : (stat.empty ? '0 : top_q);
      out_status <= cmd.out_status;
      out_depth  <= DEPTH_W'(cnt);
    end
  end

endmodule

### src/rsc_controller.sv
// ----------------------------------------------------------------------------
// rsc_controller
// Operation sequencer: decodes each item and steps the datapath through
// reads, arithmetic and write-back.
// ----------------------------------------------------------------------------
module rsc_controller import rsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kind_t     kind_in,
  input  rsc_stat_t stat,
  output rsc_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_RD_WAIT = 9'b000000100,
    S_MUL     = 9'b000001000,
    S_DSTART  = 9'b000010000,
    S_DIV     = 9'b000100000,
    S_WR1     = 9'b001000000,
    S_WR2     = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t  state;
  state_t  state_next;
  kind_t   kind_q;
  status_t status_q;
  status_t status_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    status_next     = status_q;
    cmd             = '0;
    cmd.op          = kind_q;
    cmd.wr_sel      = WR_NONE;
    cmd.out_status  = status_q;
    cmd.show_pop    = (kind_q == K_POP);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in  = 1'b1;
          status_next = ST_OK;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_OUT;
        case (kind_q)
          K_PUSH: begin
            if (stat.full) begin
              status_next = ST_OVER;
            end else begin
              cmd.wr_sel = WR_PUSH;
            end
          end
          K_POP: begin
            cmd.cap_pop = 1'b1;
            if (stat.empty) begin
              status_next = ST_UNDER;
            end else begin
              cmd.cnt_dec = 1'b1;
              cmd.rd_en   = 1'b1;
              state_next  = S_RD_WAIT;
            end
          end
          K_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          default: begin
            if (stat.lt2) begin
              status_next = ST_UNDER;
            end else if (kind_q == K_DIV && stat.top_zero) begin
              status_next = ST_DIVZ;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_RD_WAIT;
            end
          end
        endcase
      end
      S_RD_WAIT: begin
        if (kind_q == K_POP) begin
          cmd.load_top_rd = 1'b1;
          state_next      = S_OUT;
        end else begin
          cmd.cap_b = 1'b1;
          case (kind_q)
            K_MUL:   state_next = S_MUL;
            K_DIV:   state_next = S_DSTART;
            default: state_next = S_WR1;
          endcase
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_next = S_WR1;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_WR1;
        end
      end
      S_WR1: begin
        cmd.wr_sel = WR_LOW;
        if (kind_q == K_ADD || kind_q == K_SUB || kind_q == K_MUL) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_OUT;
        end else begin
          state_next = S_WR2;
        end
      end
      S_WR2: begin
        cmd.wr_sel = WR_HIGH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    if (cmd.cap_in) begin
      kind_q <= kind_in;
    end
  end

endmodule

### tb/tb_rpn_stack_calculator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_calculator
// Self-checking testbench for the stack calculator. A behavioral stack model
// predicts each output beat from the accepted input beats. A directed pass
// covers the corner cases, a held-off receiver fills the block, and random
// runs, first with idling on both ports and then without, exercise the rest.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator;
  import rsc_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
    logic [4:0]  depth;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] operand
  logic [2:0]  s_tuser = '0;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] top_or_popped, [36:32] depth, zero pad
  logic [1:0]  m_tuser;        // [1:0] status

  rpn_stack_calculator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behavioral copy of the stack.
  logic [31:0] stack_mem [STACK_DEPTH];
  int          stack_fill = 0;

  calc_result_t pending_results [$];
  bit          idling_on = 1'b1;
  int          hold_req = 0;
  int          error_count = 0;
  int          items_sent = 0;
  int          beats_checked = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          kind_seen [8] = '{0, 0, 0, 0, 0, 0, 0, 0};

  // Signed division truncating toward zero, done on magnitudes so that the
  // minimum divided by minus one wraps back to the minimum.
  function automatic void trunc_divide(input logic [31:0] num, input logic [31:0] den,
                                       output logic [31:0] quo, output logic [31:0] rem);
    logic [31:0] nmag;
    logic [31:0] dmag;
    logic [31:0] q;
    logic [31:0] r;
    nmag = num[31] ? (32'd0 - num) : num;
    dmag = den[31] ? (32'd0 - den) : den;
    q = nmag / dmag;
    r = nmag % dmag;
    quo = (num[31] != den[31]) ? (32'd0 - q) : q;
    rem = num[31] ? (32'd0 - r) : r;
  endfunction

  function automatic calc_result_t apply_stack_op(input kind_t k, input logic [31:0] opnd);
    calc_result_t res;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  q;
    logic [31:0]  r;
    logic [31:0]  popped;
    bit           show_popped;
    res.status = ST_OK;
    show_popped = 1'b0;
    popped = '0;
    case (k)
      K_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mem[stack_fill] = opnd;
          stack_fill++;
        end
      end
      K_POP: begin
        show_popped = 1'b1;
        if (stack_fill == 0) begin
          res.status = ST_UNDER;
          popped = INT_MIN;
        end else begin
          stack_fill--;
          popped = stack_mem[stack_fill];
        end
      end
      K_CLEAR: begin
        stack_fill = 0;
      end
      default: begin
        if (stack_fill < 2) begin
          res.status = ST_UNDER;
        end else begin
          a = stack_mem[stack_fill-1];
          b = stack_mem[stack_fill-2];
          case (k)
            K_ADD: begin
              stack_mem[stack_fill-2] = b + a;
              stack_fill--;
            end
            K_SUB: begin
              stack_mem[stack_fill-2] = b - a;
              stack_fill--;
            end
            K_MUL: begin
              stack_mem[stack_fill-2] = b * a;
              stack_fill--;
            end
            K_DIV: begin
              if (a == '0) begin
                res.status = ST_DIVZ;
              end else begin
                trunc_divide(b, a, q, r);
                stack_mem[stack_fill-2] = r;
                stack_mem[stack_fill-1] = q;
              end
            end
            default: begin
              stack_mem[stack_fill-1] = b;
              stack_mem[stack_fill-2] = a;
            end
          endcase
        end
      end
    endcase
    if (show_popped) res.value = popped;
    else res.value = (stack_fill == 0) ? 32'd0 : stack_mem[stack_fill-1];
    res.depth = stack_fill[4:0];
    return res;
  endfunction

  // Sends one beat, with an occasional gap in front of it.
  task automatic send_op(input kind_t k, input logic [31:0] opnd);
    if (idling_on && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= opnd;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_stack_op(k, opnd));
    kind_seen[k]++;
    items_sent++;
  endtask

  // With nothing outstanding the input is already idle.
  task automatic wait_drained();
    if (pending_results.size() != 0) begin
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return INT_MIN;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    static int hold_left = 0;
    static int stall_left = 0;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 99) < 8) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Output checker.
  always @(posedge clk) begin
    calc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output beat: value %h status %0d depth %0d",
               m_tdata[31:0], m_tuser, m_tdata[36:32]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        status_seen[m_tuser]++;
        if (m_tdata[31:0] !== want.value) begin
          $error("top_or_popped: expected %h, got %h", want.value, m_tdata[31:0]);
          error_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tdata[36:32] !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, m_tdata[36:32]);
          error_count++;
        end
      end
    end
  end

  task automatic test_corner_cases();
    send_op(K_CLEAR, 32'h0);
    send_op(K_POP,   32'hdead_beef);   // pop on an empty stack
    send_op(K_ADD,   32'h0);           // binary op on an empty stack
    send_op(K_PUSH,  32'h7fff_ffff);
    send_op(K_SWAP,  32'h0);           // swap with a single entry
    send_op(K_PUSH,  32'h1);
    send_op(K_ADD,   32'h0);           // wraps to the minimum
    send_op(K_PUSH,  32'hffff_ffff);
    send_op(K_DIV,   32'h0);           // minimum divided by minus one
    send_op(K_MUL,   32'h0);
    send_op(K_PUSH,  INT_MIN);
    send_op(K_PUSH,  32'hffff_ffff);
    send_op(K_MUL,   32'h0);           // minimum times minus one wraps
    send_op(K_PUSH,  32'hffff_fff9);
    send_op(K_PUSH,  32'h2);
    send_op(K_DIV,   32'h0);           // negative dividend, remainder negative
    send_op(K_SWAP,  32'h0);
    send_op(K_SUB,   32'h0);
    send_op(K_PUSH,  32'h0);
    send_op(K_DIV,   32'h0);           // division by zero
    send_op(K_POP,   32'h0);
    send_op(K_PUSH,  32'h7);
    send_op(K_PUSH,  32'hffff_fffe);
    send_op(K_DIV,   32'h0);           // positive by negative
    send_op(K_CLEAR, 32'h0);
    wait_drained();
  endtask

  // The receiver holds off first, and the stack is then filled past its limit.
  task automatic test_output_hold();
    hold_req = 300;
    send_op(K_CLEAR, 32'h0);
    for (int i = 0; i < STACK_DEPTH + 3; i++) send_op(K_PUSH, $urandom);
    for (int i = 0; i < 4; i++) send_op(K_ADD, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_ops(input int n);
    bit    push_heavy;
    int    r;
    kind_t k;
    push_heavy = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) push_heavy = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        k = kind_t'($urandom_range(0, 7));
      end else if (stack_fill < 2) begin
        k = (r < 88) ? K_PUSH : kind_t'($urandom_range(1, 6));
      end else if (r < (push_heavy ? 55 : 32)) begin
        k = K_PUSH;
      end else if (r < 98) begin
        k = kind_t'($urandom_range(1, 6));
      end else begin
        k = K_CLEAR;
      end
      send_op(k, (k == K_PUSH) ? rand_operand() : $urandom);
      // Now and then let the block empty out completely.
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_output_hold();
    test_random_ops(1500);
    idling_on = 1'b0;
    test_random_ops(250);
    repeat (60) @(posedge clk);
    $display("summary: %0d beats sent, %0d checked; push %0d pop %0d div %0d",
             items_sent, beats_checked, kind_seen[K_PUSH], kind_seen[K_POP],
             kind_seen[K_DIV]);
    $display("summary: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIVZ]);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
